FILE: hdl/led_color_effect_engine_top_assert.svh
// Assertion macros for the LED color effect engine top level.
// Expects signals clk and rst_n in the scope of use.
`ifndef LED_COLOR_EFFECT_ENGINE_TOP_ASSERT_SVH
`define LED_COLOR_EFFECT_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCEE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcee assertion failed");

// next-cycle implication, checked out of reset
`define LCEE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcee assertion failed");

`endif

FILE: hdl/lcee_pkg.sv
// Shared types and constants of the LED color effect engine.
// No dependencies.
`default_nettype none

package lcee_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_MODE  = 2'd3
    } op_t;

    localparam int unsigned CfgBrightness = 0;
    localparam int unsigned CfgSaturation = 1;

    localparam logic [7:0] FullScale = 8'd255;
    localparam logic [8:0] HueLast   = 9'd359;
    localparam logic [8:0] SectorSpan = 9'd60;

    // floor(p/60) = (p * Recip60) >> Div60Shift for p below 2^14
    localparam logic [31:0] Recip60    = 32'd17477;
    localparam int unsigned Div60Shift = 20;

    // operand set for the shared multiply-divide unit
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic       div60;
    } unit_req_t;

    // finished color from the sequencer
    typedef struct packed {
        logic       valid;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] red;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/lcee_muldiv.sv
// Shared multiply-then-divide unit: q = a*b/255 or a*b/60, floor.
// Two register stages, one result per cycle. Uses lcee_pkg.
`default_nettype none

module lcee_muldiv
(
    input  wire                  clk,
    input  lcee_pkg::unit_req_t  req,
    output logic [7:0]           q
);

    logic [15:0] prod_reg;
    logic        div60_reg;
    logic [7:0]  q_reg;
    logic [7:0]  q_next;
    logic [15:0] sum255;
    logic [31:0] scaled60;

    always_comb
    begin
        // exact floor(x/255) for any 16-bit x below 65280
        sum255   = 16'(prod_reg + 16'(prod_reg[15:8]) + 16'd1);
        scaled60 = 32'(prod_reg) * lcee_pkg::Recip60;
        if (div60_reg)
            q_next = scaled60[lcee_pkg::Div60Shift +: 8];
        else
            q_next = sum255[15:8];
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= 16'(req.a) * 16'(req.b);
        div60_reg <= req.div60;
        q_reg     <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

FILE: hdl/lcee_ctrl.sv
// Sequencer of the LED color effect engine: decodes items, holds hue and
// rainbow state, and drives the shared multiply-divide unit. Uses lcee_pkg.
`default_nettype none

module lcee_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  lcee_pkg::op_t        in_op,
    input  wire [7:0]            in_red,
    input  wire [7:0]            in_green,
    input  wire [7:0]            in_blue,
    input  wire                  in_start,
    input  wire [7:0]            brightness,
    input  wire [7:0]            saturation,
    output lcee_pkg::unit_req_t  req,
    input  wire [7:0]            q,
    output lcee_pkg::res_t       res,
    input  wire                  res_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET,
        ST_TICK,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic [2:0] cnt_reg;
    logic [8:0] hue_reg;
    logic       rainbow_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] mn_reg;
    logic [7:0] res_red_reg;
    logic [7:0] res_green_reg;
    logic [7:0] res_blue_reg;

    logic [2:0] sector;
    logic [8:0] sector_base;
    logic [5:0] rem;
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] hsv_red;
    logic [7:0] hsv_green;
    logic [7:0] hsv_blue;

    // hue sector and position inside it
    always_comb
    begin
        priority if (hue_reg < 9'd60)
        begin
            sector = 3'd0;
            sector_base = 9'd0;
        end
        else if (hue_reg < 9'd120)
        begin
            sector = 3'd1;
            sector_base = lcee_pkg::SectorSpan;
        end
        else if (hue_reg < 9'd180)
        begin
            sector = 3'd2;
            sector_base = 9'd120;
        end
        else if (hue_reg < 9'd240)
        begin
            sector = 3'd3;
            sector_base = 9'd180;
        end
        else if (hue_reg < 9'd300)
        begin
            sector = 3'd4;
            sector_base = 9'd240;
        end
        else
        begin
            sector = 3'd5;
            sector_base = 9'd300;
        end
        rem = 6'(hue_reg - sector_base);
    end

    // color assembly once ramp (q) is back
    always_comb
    begin
        up   = 8'(mn_reg + q);
        down = 8'(brightness - q);
        unique case (sector)
            3'd0:
            begin
                hsv_red = brightness; hsv_green = up; hsv_blue = mn_reg;
            end
            3'd1:
            begin
                hsv_red = down; hsv_green = brightness; hsv_blue = mn_reg;
            end
            3'd2:
            begin
                hsv_red = mn_reg; hsv_green = brightness; hsv_blue = up;
            end
            3'd3:
            begin
                hsv_red = mn_reg; hsv_green = down; hsv_blue = brightness;
            end
            3'd4:
            begin
                hsv_red = up; hsv_green = mn_reg; hsv_blue = brightness;
            end
            default:
            begin
                hsv_red = brightness; hsv_green = mn_reg; hsv_blue = down;
            end
        endcase
    end

    // operands for the shared unit
    always_comb
    begin
        req.b     = brightness;
        req.div60 = 1'b0;
        unique case (state_reg)
            ST_SET:
            begin
                priority if (cnt_reg == 3'd0)
                    req.a = red_reg;
                else if (cnt_reg == 3'd1)
                    req.a = green_reg;
                else
                    req.a = blue_reg;
            end
            ST_TICK:
            begin
                if (cnt_reg == 3'd2)
                begin
                    // ramp = (v - mn) * rem / 60, mn arriving now
                    req.a     = 8'(brightness - q);
                    req.b     = 8'(rem);
                    req.div60 = 1'b1;
                end
                else
                begin
                    // mn = v * (255 - s) / 255
                    req.a = brightness;
                    req.b = 8'(lcee_pkg::FullScale - saturation);
                end
            end
            default:
            begin
                req.a = brightness;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 3'd0;
            hue_reg     <= 9'd0;
            rainbow_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        red_reg   <= in_red;
                        green_reg <= in_green;
                        blue_reg  <= in_blue;
                        cnt_reg   <= 3'd0;
                        unique case (in_op)
                            lcee_pkg::OP_TICK:
                            begin
                                if (rainbow_reg)
                                    state_reg <= ST_TICK;
                            end
                            lcee_pkg::OP_SET:
                            begin
                                if (!rainbow_reg)
                                    state_reg <= ST_SET;
                            end
                            lcee_pkg::OP_CLEAR:
                            begin
                                res_red_reg   <= 8'd0;
                                res_green_reg <= 8'd0;
                                res_blue_reg  <= 8'd0;
                                state_reg     <= ST_DONE;
                            end
                            lcee_pkg::OP_MODE:
                            begin
                                if (in_start)
                                begin
                                    if (!rainbow_reg)
                                    begin
                                        rainbow_reg <= 1'b1;
                                        hue_reg     <= 9'd0;
                                    end
                                end
                                else if (rainbow_reg)
                                begin
                                    rainbow_reg   <= 1'b0;
                                    res_red_reg   <= 8'd0;
                                    res_green_reg <= 8'd0;
                                    res_blue_reg  <= 8'd0;
                                    state_reg     <= ST_DONE;
                                end
                            end
                        endcase
                    end
                end
                ST_SET:
                begin
                    cnt_reg <= 3'(cnt_reg + 3'd1);
                    if (cnt_reg == 3'd2)
                        res_red_reg <= q;
                    if (cnt_reg == 3'd3)
                        res_green_reg <= q;
                    if (cnt_reg == 3'd4)
                    begin
                        res_blue_reg <= q;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_TICK:
                begin
                    cnt_reg <= 3'(cnt_reg + 3'd1);
                    if (cnt_reg == 3'd2)
                        mn_reg <= q;
                    if (cnt_reg == 3'd4)
                    begin
                        res_red_reg   <= hsv_red;
                        res_green_reg <= hsv_green;
                        res_blue_reg  <= hsv_blue;
                        // advance hue, wrap at full circle
                        if (hue_reg >= lcee_pkg::HueLast)
                            hue_reg <= 9'd0;
                        else
                            hue_reg <= 9'(hue_reg + 9'd1);
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_ready)
                        state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_DONE);
    assign res.green = res_green_reg;
    assign res.blue  = res_blue_reg;
    assign res.red   = res_red_reg;

endmodule

`default_nettype wire

FILE: hdl/led_color_effect_engine_top.sv
// Latency: clear and stop give a result 1 cycle after the transfer in;
// tick and set color first step their products through the shared multiply-divide unit.
// Input: one item at a time; the next is taken only when the sequencer is idle again,
// after its result has gone to the output register. Items with no result leave it idle.
// Reset: rainbow off, hue 0, brightness and saturation 255, no output pending.
// Uses lcee_pkg, lcee_ctrl, lcee_muldiv and the assertion header.
`default_nettype none
`include "led_color_effect_engine_top_assert.svh"

module led_color_effect_engine_top
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16], rainbow_on [24], zero [31:25]
    input  wire [31:0]  s_axis_tdata,
    // operation [1:0]
    input  wire [1:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // led_green [7:0], led_blue [15:8], led_red [23:16]
    output logic [23:0] m_axis_tdata,
    input  wire         cfg_we,
    input  wire [0:0]   cfg_index,
    input  wire [7:0]   cfg_data
);

    logic [7:0]          brightness_reg;
    logic [7:0]          saturation_reg;
    logic                out_valid_reg;
    logic [23:0]         out_data_reg;
    logic                res_ready;
    lcee_pkg::unit_req_t req;
    logic [7:0]          q;
    lcee_pkg::res_t      res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= lcee_pkg::FullScale;
            saturation_reg <= lcee_pkg::FullScale;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(lcee_pkg::CfgBrightness))
                brightness_reg <= cfg_data;
            if (cfg_index == 1'(lcee_pkg::CfgSaturation))
                saturation_reg <= cfg_data;
        end
    end

    lcee_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (lcee_pkg::op_t'(s_axis_tuser)),
        .in_red     (s_axis_tdata[7:0]),
        .in_green   (s_axis_tdata[15:8]),
        .in_blue    (s_axis_tdata[23:16]),
        .in_start   (s_axis_tdata[24]),
        .brightness (brightness_reg),
        .saturation (saturation_reg),
        .req        (req),
        .q          (q),
        .res        (res),
        .res_ready  (res_ready)
    );

    lcee_muldiv u_muldiv
    (
        .clk (clk),
        .req (req),
        .q   (q)
    );

    // output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res.valid && res_ready)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
            out_data_reg <= {res.red, res.blue, res.green};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `LCEE_ASSERT_NOW(a_ready_no_result, s_axis_tready, !res.valid)
    `LCEE_ASSERT_NEXT(a_clear_gives_result, s_axis_tvalid && s_axis_tready && (s_axis_tuser == lcee_pkg::OP_CLEAR), res.valid)
    `LCEE_ASSERT_NEXT(a_result_loads_output, res.valid && res_ready, m_axis_tvalid)

endmodule

`default_nettype wire

FILE: tb/sv/led_color_effect_engine_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for led_color_effect_engine_top: random and directed LED commands,
// with a built-in color predictor that checks every output transfer.
// Depends on lcee_pkg and the engine RTL only.

module led_color_effect_engine_top_test;

    import lcee_pkg::*;

    localparam int unsigned HueSpan     = 360;
    localparam int unsigned ChannelMax  = 255;
    localparam int unsigned SectorWidth = 60;
    localparam int unsigned HoldCycles  = 60;
    localparam int unsigned DrainCycles = 12;

    typedef struct packed {
        op_t        op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       rainbow_on;
    } lamp_cmd_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] blue;
        logic [7:0] green;
    } led_color_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // color predictor state
    logic [8:0]  hue = '0;
    logic        rainbow = 1'b0;
    logic [7:0]  bright = 8'd255;
    logic [7:0]  sat = 8'd255;

    lamp_cmd_t   cmd_q[$];
    led_color_t  color_q[$];
    logic        in_taken = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          hold_ask = 0;
    int          hold_grant = 0;
    bit          steady = 1'b0;
    int          err_cnt = 0;

    led_color_effect_engine_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the LED state by one command; return 1 when a color goes out.
    function automatic bit next_color(input lamp_cmd_t cmd, output led_color_t col);
        int unsigned v, mn, hh, ramp, r, g, b;
        v = bright;
        col = '0;
        next_color = 1'b0;
        case (cmd.op)
            OP_TICK:
            begin
                if (rainbow)
                begin
                    hh = hue % HueSpan;
                    mn = v * (ChannelMax - sat) / ChannelMax;
                    ramp = (v - mn) * (hh % SectorWidth) / SectorWidth;
                    case (hh / SectorWidth)
                        0: begin r = v;        g = mn + ramp; b = mn;        end
                        1: begin r = v - ramp; g = v;         b = mn;        end
                        2: begin r = mn;       g = v;         b = mn + ramp; end
                        3: begin r = mn;       g = v - ramp;  b = v;         end
                        4: begin r = mn + ramp; g = mn;       b = v;         end
                        default: begin r = v;  g = mn;        b = v - ramp;  end
                    endcase
                    col.red = r[7:0];
                    col.green = g[7:0];
                    col.blue = b[7:0];
                    hue = 9'((hue + 1) % HueSpan);
                    next_color = 1'b1;
                end
            end
            OP_SET:
            begin
                if (!rainbow)
                begin
                    r = cmd.red * v / ChannelMax;
                    g = cmd.green * v / ChannelMax;
                    b = cmd.blue * v / ChannelMax;
                    col.red = r[7:0];
                    col.green = g[7:0];
                    col.blue = b[7:0];
                    next_color = 1'b1;
                end
            end
            OP_CLEAR:
                next_color = 1'b1;
            default:
            begin
                if (cmd.rainbow_on)
                begin
                    if (!rainbow)
                    begin
                        rainbow = 1'b1;
                        hue = '0;
                    end
                end
                else if (rainbow)
                begin
                    rainbow = 1'b0;
                    next_color = 1'b1;
                end
            end
        endcase
    endfunction

    task automatic check_byte(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    function automatic void push_cmd(input op_t op, input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic on);
        lamp_cmd_t cmd;
        cmd.op = op;
        cmd.red = r;
        cmd.green = g;
        cmd.blue = b;
        cmd.rainbow_on = on;
        cmd_q.push_back(cmd);
    endfunction

    // Queue random commands; the rest after ticks and mode changes is set or clear, 3:1.
    task automatic queue_random(input int count, input int tick_pct, input int mode_pct);
        int   pick;
        op_t  op;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct)
                op = OP_TICK;
            else if (pick < tick_pct + mode_pct)
                op = OP_MODE;
            else if ($urandom_range(0, 3) == 0)
                op = OP_CLEAR;
            else
                op = OP_SET;
            push_cmd(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(input int idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = 1'(idx);
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CfgBrightness)
            bright = val;
        else
            sat = val;
    endtask

    task automatic set_levels(input logic [7:0] bright_val, input logic [7:0] sat_val);
        write_reg(CfgBrightness, bright_val);
        write_reg(CfgSaturation, sat_val);
    endtask

    // Wait for every queued command to go in and every color to come out,
    // then give commands that produce nothing time to finish.
    task automatic settle();
        do
            @(posedge clk);
        while (cmd_q.size() != 0 || s_axis_tvalid || color_q.size() != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // command driver
    always @(negedge clk)
    begin : drive_cmd
        lamp_cmd_t cmd;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                cmd = cmd_q.pop_front();
                s_axis_tuser <= cmd.op;
                s_axis_tdata <= {7'd0, cmd.rainbow_on, cmd.blue, cmd.green, cmd.red};
                s_axis_tvalid <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 5);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output side: long hold on request, otherwise short random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_grant != hold_ask)
        begin
            hold_grant = hold_ask;
            hold_left = HoldCycles - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // monitor: check output transfers first, then predict from input transfers
    always @(posedge clk)
    begin : watch_ports
        lamp_cmd_t  cmd;
        led_color_t col;
        led_color_t want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (color_q.size() == 0)
                begin
                    err_cnt++;
                    $error("output transfer with no color expected: tdata %h", m_axis_tdata);
                end
                else
                begin
                    want = color_q.pop_front();
                    check_byte("led_green", want.green, m_axis_tdata[7:0]);
                    check_byte("led_blue", want.blue, m_axis_tdata[15:8]);
                    check_byte("led_red", want.red, m_axis_tdata[23:16]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                cmd.op = op_t'(s_axis_tuser);
                cmd.red = s_axis_tdata[7:0];
                cmd.green = s_axis_tdata[15:8];
                cmd.blue = s_axis_tdata[23:16];
                cmd.rainbow_on = s_axis_tdata[24];
                if (next_color(cmd, col))
                    color_q.push_back(col);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every command in both modes, at reset levels
        push_cmd(OP_TICK, 8'hff, 8'hff, 8'hff, 1'b1);    // rainbow off: nothing
        push_cmd(OP_SET, 8'hff, 8'hff, 8'hff, 1'b0);
        push_cmd(OP_SET, 8'h00, 8'h00, 8'h00, 1'b1);
        push_cmd(OP_SET, 8'h80, 8'h01, 8'hfe, 1'b0);
        push_cmd(OP_CLEAR, 8'h55, 8'haa, 8'h0f, 1'b1);
        push_cmd(OP_MODE, 8'h00, 8'h00, 8'h00, 1'b0);    // stop while off
        push_cmd(OP_MODE, 8'hff, 8'hff, 8'hff, 1'b1);    // start: hue back to 0
        push_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        push_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1);
        push_cmd(OP_MODE, 8'h12, 8'h34, 8'h56, 1'b1);    // start while on: keep hue
        push_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        push_cmd(OP_SET, 8'hff, 8'h00, 8'hff, 1'b0);     // ignored while on
        push_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0);   // black, rainbow keeps going
        push_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        push_cmd(OP_MODE, 8'h00, 8'h00, 8'h00, 1'b0);    // stop while on: black
        push_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        push_cmd(OP_MODE, 8'h00, 8'h00, 8'h00, 1'b1);
        push_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        push_cmd(OP_MODE, 8'h00, 8'h00, 8'h00, 1'b0);
        settle();

        set_levels(8'd200, 8'd100);
        queue_random(110, 40, 10);
        settle();

        // full hue wheel under a long output hold
        set_levels(8'd255, 8'd255);
        hold_ask++;
        push_cmd(OP_MODE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b1);
        queue_random(420, 92, 0);
        settle();

        set_levels(8'd0, 8'd255);
        queue_random(90, 40, 10);
        settle();

        set_levels(8'd255, 8'd0);
        queue_random(90, 40, 10);
        settle();

        set_levels(8'd0, 8'd0);
        queue_random(60, 40, 10);
        settle();

        for (int i = 0; i < 3; i++)
        begin
            set_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            queue_random(80, 50, 8);
            settle();
        end

        // closing stretch with no idling on either side
        steady = 1'b1;
        set_levels(8'd1, 8'd254);
        queue_random(110, 45, 10);
        settle();

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
